FILE: hdl/count_decreasing_subsequences_len_k_macros.svh
// assertion macros for the decreasing subsequence counter
`ifndef COUNT_DECREASING_SUBSEQUENCES_LEN_K_MACROS_SVH
`define COUNT_DECREASING_SUBSEQUENCES_LEN_K_MACROS_SVH
`ifndef SYNTH
`define CDSK_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("cdsk check failed");
`define CDSK_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("cdsk check failed");
`define CDSK_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("cdsk check failed");
`else
`define CDSK_ASSERT(lbl, cond)
`define CDSK_ASSERT_IMPL(lbl, pre, post)
`define CDSK_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: hdl/cdsk_pkg.sv
// shared types, constants and modular add for the decreasing subsequence counter
package cdsk_pkg;
    localparam int COUNT_W = 30;
    typedef logic [COUNT_W-1:0] count_t;
    localparam count_t COUNT_MOD = 30'd1000000000;

    function automatic count_t add_mod(input count_t a, input count_t b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COUNT_MOD}) begin
            s = s - {1'b0, COUNT_MOD};
        end
        return s[COUNT_W-1:0];
    endfunction
endpackage

FILE: hdl/count_decreasing_subsequences_len_k.sv
// counts strictly decreasing subsequences of a set length, one fenwick tree per level in ram
// each push walks up to seq_length levels (at most MAX_LEN): a fenwick query of the level below
//   (read, accumulate), then a read-modify-write update, and at the top level a read of its total
// a clear, and the pass after reset, sweep the ram at one word a cycle: MAX_LEN * 2^log2(NUM_VALUES)
// one item at a time; the next item is taken while the last result still waits on m_
// aresetn is synchronous active low; seq_length returns to 1 and the ram is swept to zero
`include "count_decreasing_subsequences_len_k_macros.svh"
module count_decreasing_subsequences_len_k #(
    parameter int NUM_VALUES = 1024,
    parameter int MAX_LEN    = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,    // seq_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // value [9:0], zero fill
    input  logic [0:0]  s_tuser,     // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata      // count [29:0], zero fill
);
    localparam int AW     = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
    localparam int LW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int P      = 1 << AW;
    localparam int DEPTH  = MAX_LEN * P;
    localparam int ADDR_W = LW + AW;
    localparam int IW     = AW + 2;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_QRD  = 4'd2;
    localparam logic [3:0] S_QACC = 4'd3;
    localparam logic [3:0] S_URD  = 4'd4;
    localparam logic [3:0] S_UWR  = 4'd5;
    localparam logic [3:0] S_TRD  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic [3:0]          seq_length_reg;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic [LW:0]         k_reg, k_next;
    logic [IW-1:0]       r_reg, r_next;
    logic [IW-1:0]       idx_reg, idx_next;
    cdsk_pkg::count_t    acc_reg, acc_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                clr_out_reg, clr_out_next;
    logic                zero_reg, zero_next;
    logic                m_tvalid_reg;
    cdsk_pkg::count_t    m_count_reg;

    cdsk_pkg::count_t    mem [DEPTH];
    cdsk_pkg::count_t    rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic                wr_en;
    cdsk_pkg::count_t    wr_data;

    logic [IW-1:0]       lowbit, idx_up, idx_dn;
    logic                out_free, load_out;
    logic [31:0]         v32, v_sat, r32;
    logic [LW:0]         k_sat;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, m_count_reg};
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = (state_reg == S_OUT) && out_free;

    assign lowbit = idx_reg & (~idx_reg + 1'b1);
    assign idx_up = idx_reg + lowbit;
    assign idx_dn = idx_reg - lowbit;

    // values above the range clamp to the top; index is reversed so suffix sums become prefixes
    assign v32   = {22'd0, s_tdata[9:0]};
    assign v_sat = (v32 >= 32'(NUM_VALUES)) ? 32'(NUM_VALUES - 1) : v32;
    assign r32   = 32'(P) - v_sat;
    assign k_sat = (int'(seq_length_reg) > MAX_LEN) ? (LW+1)'(MAX_LEN)
                                                    : (LW+1)'(seq_length_reg);

    always_comb begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_out_next = clr_out_reg;
        zero_next    = zero_reg;
        rd_addr      = {lvl_reg, idx_reg[AW-1:0]};
        wr_addr      = {lvl_reg, idx_reg[AW-1:0]};
        wr_en        = 1'b0;
        wr_data      = cdsk_pkg::add_mod(rd_data_reg, acc_reg);
        case (state_reg)
            S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    clr_cnt_next = '0;
                    clr_out_next = 1'b0;
                    zero_next    = 1'b1;
                    state_next   = clr_out_reg ? S_OUT : S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser[0]) begin
                        clr_out_next = 1'b1;
                        state_next   = S_CLR;
                    end else if (k_sat == '0) begin
                        zero_next  = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        zero_next  = 1'b0;
                        k_next     = k_sat;
                        lvl_next   = '0;
                        r_next     = r32[IW-1:0];
                        idx_next   = r32[IW-1:0];
                        acc_next   = cdsk_pkg::count_t'(1);
                        state_next = S_URD;
                    end
                end
            end
            S_QRD: begin
                rd_addr    = {lvl_reg - 1'b1, idx_reg[AW-1:0]};
                state_next = S_QACC;
            end
            S_QACC: begin
                acc_next = cdsk_pkg::add_mod(acc_reg, rd_data_reg);
                if (idx_dn == '0) begin
                    idx_next   = r_reg;
                    state_next = S_URD;
                end else begin
                    idx_next   = idx_dn;
                    state_next = S_QRD;
                end
            end
            S_URD: begin
                state_next = S_UWR;
            end
            S_UWR: begin
                wr_en = 1'b1;
                if (idx_up > IW'(P)) begin
                    // level finished, move up or read the total of the top level
                    if ({1'b0, lvl_reg} + 1'b1 < k_reg) begin
                        lvl_next = lvl_reg + 1'b1;
                        acc_next = '0;
                        if (r_reg == IW'(1)) begin
                            idx_next   = r_reg;
                            state_next = S_URD;
                        end else begin
                            idx_next   = r_reg - 1'b1;
                            state_next = S_QRD;
                        end
                    end else begin
                        idx_next   = '0;
                        state_next = S_TRD;
                    end
                end else begin
                    idx_next   = idx_up;
                    state_next = S_URD;
                end
            end
            S_TRD: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            seq_length_reg <= 4'd1;
            clr_cnt_reg    <= '0;
            clr_out_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_out_reg <= clr_out_next;
            if (cfg_valid) begin
                seq_length_reg <= cfg_data;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg  <= lvl_next;
        k_reg    <= k_next;
        r_reg    <= r_next;
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        zero_reg <= zero_next;
        if (load_out) begin
            m_count_reg <= zero_reg ? '0 : rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    `CDSK_ASSERT_IMPL(a_count_range, m_tvalid_reg, m_count_reg < cdsk_pkg::COUNT_MOD)
    `CDSK_ASSERT_IMPL(a_wr_range, wr_en, wr_data < cdsk_pkg::COUNT_MOD)
    `CDSK_ASSERT_NEXT(a_query_step, state_reg == S_QRD, state_reg == S_QACC)
    `CDSK_ASSERT_IMPL(a_acc_range, state_reg == S_UWR, acc_reg < cdsk_pkg::COUNT_MOD)
endmodule

FILE: bench/count_decreasing_subsequences_len_k_tb.sv
// self-checking testbench for the decreasing subsequence counter
`timescale 1ns / 100ps
module count_decreasing_subsequences_len_k_tb;
    localparam int NVAL = 1024;
    localparam int LEVELS = 10;
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_PUSH = 1'b1;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic       cmd;
        logic [9:0] value;
    } seq_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;

    count_decreasing_subsequences_len_k uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // per-level counts by value, mirror of the block's trees
    cdsk_pkg::count_t ends_at[LEVELS][NVAL];
    logic [3:0] cur_len;
    seq_item_t pending_items[$];
    cdsk_pkg::count_t expected_counts[$];
    bit failed = 0;
    bit idle_enable = 0;
    int idle_cycles = 0;

    function automatic cdsk_pkg::count_t add_mod_tb(cdsk_pkg::count_t a, cdsk_pkg::count_t b);
        logic [31:0] s;
        s = 32'(a) + 32'(b);
        if (s >= 32'd1000000000) s = s - 32'd1000000000;
        return s[29:0];
    endfunction

    function automatic cdsk_pkg::count_t sum_above(int lvl, int lo);
        cdsk_pkg::count_t acc = '0;
        for (int u = lo; u < NVAL; u++) acc = add_mod_tb(acc, ends_at[lvl][u]);
        return acc;
    endfunction

    function automatic cdsk_pkg::count_t predict_count(seq_item_t it);
        int k;
        int v;
        cdsk_pkg::count_t inc;
        k = (cur_len > LEVELS) ? LEVELS : cur_len;
        v = it.value;
        if (it.cmd == CMD_CLEAR) begin
            foreach (ends_at[l, u]) ends_at[l][u] = '0;
            return '0;
        end
        for (int l = 0; l < k; l++) begin
            inc = (l == 0) ? cdsk_pkg::count_t'(1) : sum_above(l - 1, v + 1);
            ends_at[l][v] = add_mod_tb(ends_at[l][v], inc);
        end
        if (k == 0) return '0;
        return sum_above(k - 1, 0);
    endfunction

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (idle_enable) m_tready <= ($urandom_range(99) >= 36);
        else m_tready <= 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && !(idle_enable && $urandom_range(99) < 36)) begin
                    seq_item_t it;
                    it = pending_items.pop_front();
                    expected_counts.push_back(predict_count(it));
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, it.value};
                    s_tuser <= it.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %0d", $time,
                             m_tdata[29:0]);
                    failed = 1;
                end else begin
                    cdsk_pkg::count_t want;
                    want = expected_counts.pop_front();
                    if (m_tdata[29:0] !== want) begin
                        $display("%0t count mismatch: expected %0d, actual %0d", $time, want,
                                 m_tdata[29:0]);
                        failed = 1;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic push_item(logic cmd, int value);
        seq_item_t it;
        it.cmd = cmd;
        it.value = value[9:0];
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_counts.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_len(int len);
        cfg_data <= len[3:0];
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_len = len[3:0];
    endtask

    // a random run: mostly values in a window of span above a random base, some anywhere, a few clears
    task automatic random_phase(int n, int span);
        int base;
        base = $urandom_range(NVAL - 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 2) push_item(CMD_CLEAR, $urandom);
            else if ($urandom_range(99) < 15) push_item(CMD_PUSH, $urandom_range(NVAL - 1));
            else push_item(CMD_PUSH, (base + $urandom_range(span)) % NVAL);
        end
    endtask

    initial begin
        int lens[8];
        foreach (ends_at[l, u]) ends_at[l][u] = '0;
        cur_len = 4'd1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, repeats, clear, length zero and above the maximum
        push_item(CMD_PUSH, 0);
        push_item(CMD_PUSH, 1023);
        push_item(CMD_PUSH, 1023);
        push_item(CMD_CLEAR, 1023);
        drain();
        write_len(10);
        for (int i = 0; i < 12; i++) push_item(CMD_PUSH, 1023 - i * 93);
        push_item(CMD_PUSH, 682);
        drain();
        write_len(0);
        push_item(CMD_PUSH, 5);
        push_item(CMD_PUSH, 341);
        drain();
        write_len(15);
        push_item(CMD_PUSH, 3);
        push_item(CMD_PUSH, 2);
        push_item(CMD_CLEAR, 0);
        drain();

        idle_enable = 1;
        lens = '{3, 1, 10, 2, 12, 5, 0, 4};
        for (int p = 0; p < 8; p++) begin
            write_len(lens[p]);
            // one phase without idling
            idle_enable = (p != 2);
            random_phase(100, (p % 2) ? 1023 : 40);
            drain();
        end

        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
